>>> design/led_grid_command_decoder_macros.svh
// Assertion macros of the LED grid command decoder, used by the expander.
`ifndef LED_GRID_COMMAND_DECODER_MACROS_SVH
`define LED_GRID_COMMAND_DECODER_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define LGCD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must never hold.
`define LGCD_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> design/lgcd_pkg.sv
// Package: types, codes and constants of the LED grid command decoder.
`timescale 1ns / 1ps
package lgcd_pkg;

	localparam int MAX_MESSAGE_BYTES = 4096;
	localparam int JOB_DEPTH         = 4;
	localparam int JOB_PTR_W         = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W         = $clog2(JOB_DEPTH + 1);

	// Result command codes
	localparam logic [1:0] CMD_FILL   = 2'd0;
	localparam logic [1:0] CMD_SET    = 2'd1;
	localparam logic [1:0] CMD_COMMIT = 2'd2;

	// Message byte fields and address codes
	localparam int         COUNT_FLAG_BIT = 6;
	localparam logic [7:0] LEVEL_MASK     = 8'h3F;
	localparam logic [7:0] ADDR_FILL      = 8'd0;
	localparam logic [7:0] ADDR_SKIP      = 8'd99;
	localparam logic [7:0] ADDR_ROW_LO    = 8'd100;
	localparam logic [7:0] ADDR_ROW_HI    = 8'd109;
	localparam logic [7:0] ADDR_COL_LO    = 8'd110;
	localparam logic [7:0] ADDR_COL_HI    = 8'd119;
	localparam logic [3:0] LINE_CELLS     = 4'd8;
	localparam logic [7:0] COL_STRIDE     = 8'd10;

	typedef enum logic [2:0] {
		PH_RED,
		PH_GREEN,
		PH_BLUE,
		PH_COUNT,
		PH_ADDR
	} lgcd_phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_of_message;
		logic [12:0] bytes_left;
	} lgcd_item_t;

	typedef struct packed {
		logic [1:0] command_kind;
		logic [7:0] cell_address;
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
		logic       last_of_run;
	} lgcd_result_t;

	// One classified byte handed from the parser to the expander.
	typedef struct packed {
		logic       has_cmd;
		logic       is_fill;
		logic       line;      // eight cells instead of one
		logic       step_col;  // step by a row stride instead of one
		logic [7:0] start_addr;
		logic [5:0] red;
		logic [5:0] green;
		logic [5:0] blue;
		logic       commit;
	} lgcd_job_t;

endpackage

>>> design/lgcd_front.sv
// Parser: walks the message byte by byte and classifies each into a job.
`timescale 1ns / 1ps
module lgcd_front import lgcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lgcd_item_t item,
	input  logic       accept,
	output lgcd_job_t  job,
	output logic       job_valid
);

	lgcd_phase_t phase_q, phase_d;
	logic [5:0]  red_q, red_d;
	logic [5:0]  green_q, green_d;
	logic [5:0]  blue_q, blue_d;
	logic [7:0]  rem_q, rem_d;
	logic        abort_q, abort_d;

	logic [12:0] bl;
	logic [12:0] after;
	lgcd_phase_t ph;
	logic [7:0]  rem;
	logic        ab;
	logic [7:0]  b;

	always_comb begin
		b     = item.data_byte;
		bl    = (32'(item.bytes_left) > MAX_MESSAGE_BYTES) ? 13'(MAX_MESSAGE_BYTES)
			: item.bytes_left;
		after = (bl != 13'd0) ? bl - 13'd1 : 13'd0;
		ph    = item.first_of_message ? PH_RED : phase_q;
		rem   = item.first_of_message ? 8'd0 : rem_q;
		ab    = item.first_of_message ? 1'b0 : abort_q;
	end

	// next state
	always_comb begin
		logic [7:0] rem_b;
		logic [7:0] rem_dec;
		phase_d = ph;
		red_d   = red_q;
		green_d = green_q;
		blue_d  = blue_q;
		rem_d   = rem;
		abort_d = ab;
		rem_b   = rem | {7'd0, b[COUNT_FLAG_BIT]};
		rem_dec = (rem != 8'd0) ? rem - 8'd1 : rem;
		if (!ab) begin
			case (ph)
				PH_GREEN: begin
					green_d = 6'(b & LEVEL_MASK);
					if (b[COUNT_FLAG_BIT]) rem_d = rem | 8'd2;
					phase_d = PH_BLUE;
				end
				PH_BLUE: begin
					blue_d = 6'(b & LEVEL_MASK);
					rem_d  = rem_b;
					if (rem_b == 8'd0) phase_d = PH_COUNT;
					else if ({5'd0, rem_b} > after) abort_d = 1'b1;
					else phase_d = PH_ADDR;
				end
				PH_COUNT: begin
					if (b == 8'd0) phase_d = PH_RED;
					else if ({5'd0, b} > after) abort_d = 1'b1;
					else begin
						rem_d   = b;
						phase_d = PH_ADDR;
					end
				end
				PH_ADDR: begin
					rem_d = rem_dec;
					if (rem_dec == 8'd0) phase_d = PH_RED;
				end
				default: begin
					if (bl < 13'd3) abort_d = 1'b1;
					else begin
						red_d   = 6'(b & LEVEL_MASK);
						rem_d   = b[COUNT_FLAG_BIT] ? 8'd4 : 8'd0;
						phase_d = PH_GREEN;
					end
				end
			endcase
		end
		if (bl <= 13'd1) begin
			abort_d = 1'b1;
			phase_d = PH_RED;
			rem_d   = 8'd0;
		end
	end

	// job classification
	always_comb begin
		logic       row, col;
		logic [7:0] d;
		row = (b >= ADDR_ROW_LO) && (b <= ADDR_ROW_HI);
		col = (b >= ADDR_COL_LO) && (b <= ADDR_COL_HI);
		d   = b - ADDR_ROW_LO;  // row/column digit; column start is 10 + (a - 110)
		job.has_cmd  = !ab && (ph == PH_ADDR) && (b != ADDR_SKIP);
		job.is_fill  = (b == ADDR_FILL);
		job.line     = row || col;
		job.step_col = col;
		if (b == ADDR_FILL) job.start_addr = 8'd0;
		else if (row) job.start_addr = (d << 3) + (d << 1) + 8'd1;
		else if (col) job.start_addr = d;
		else job.start_addr = b;
		job.red    = red_q;
		job.green  = green_q;
		job.blue   = blue_q;
		job.commit = (bl <= 13'd1);
		job_valid  = accept && (job.has_cmd || job.commit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RED;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			rem_q   <= '0;
			abort_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
			rem_q   <= rem_d;
			abort_q <= abort_d;
		end
	end

endmodule

>>> design/lgcd_job_fifo.sv
// Job queue between the parser and the expander.
`timescale 1ns / 1ps
module lgcd_job_fifo import lgcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  lgcd_job_t wr_data,
	output logic      full,
	input  logic      rd_en,
	output lgcd_job_t rd_data,
	output logic      empty
);

	lgcd_job_t              entry_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [JOB_CNT_W-1:0]   count_q;

	assign full    = (count_q == JOB_CNT_W'(JOB_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) entry_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= (wr_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
				: wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= (rd_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
				: rd_ptr_q + 1'b1;
			if (wr_en && !rd_en) count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> design/lgcd_back.sv
// Expander: turns jobs into grid commands and commits, one per cycle while its output is free.
`timescale 1ns / 1ps
`include "led_grid_command_decoder_macros.svh"
module lgcd_back import lgcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lgcd_job_t    job,
	input  logic         job_empty,
	output logic         job_pop,
	output lgcd_result_t result,
	output logic         empty,
	input  logic         pop
);

	logic [3:0]   left_q;
	logic         commit_q;
	logic         fill_q;
	logic         step_col_q;
	logic [7:0]   addr_q;
	logic [5:0]   red_q, green_q, blue_q;
	logic         out_valid_q;
	lgcd_result_t out_q;

	logic         busy, emit, last, slot_free;
	lgcd_result_t res;

	assign busy      = (left_q != 4'd0) || commit_q;
	assign slot_free = !out_valid_q || pop;
	assign emit      = busy && slot_free;
	assign last      = (left_q == 4'd0) || ((left_q == 4'd1) && !commit_q);
	assign job_pop   = !job_empty && (!busy || (emit && last));
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_comb begin
		if (left_q != 4'd0) begin
			res.command_kind = fill_q ? CMD_FILL : CMD_SET;
			res.cell_address = fill_q ? 8'd0 : addr_q;
			res.red_level    = {red_q, 2'b00};
			res.green_level  = {green_q, 2'b00};
			res.blue_level   = {blue_q, 2'b00};
		end else begin
			res.command_kind = CMD_COMMIT;
			res.cell_address = 8'd0;
			res.red_level    = 8'd0;
			res.green_level  = 8'd0;
			res.blue_level   = 8'd0;
		end
		res.last_of_run = last;
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			fill_q     <= job.is_fill;
			step_col_q <= job.step_col;
			addr_q     <= job.start_addr;
			red_q      <= job.red;
			green_q    <= job.green;
			blue_q     <= job.blue;
		end else if (emit && (left_q != 4'd0)) begin
			addr_q <= addr_q + (step_col_q ? COL_STRIDE : 8'd1);
		end
		if (emit) out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			commit_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				left_q   <= !job.has_cmd ? 4'd0 : (job.line ? LINE_CELLS : 4'd1);
				commit_q <= job.commit;
			end else if (emit) begin
				if (left_q != 4'd0) left_q <= left_q - 4'd1;
				else commit_q <= 1'b0;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	`LGCD_ASSERT_IMPLY(a_load_only_when_done, job_pop && busy, emit && last, "job loaded over unfinished job")
	`LGCD_ASSERT_NEVER(a_pop_empty_queue, job_pop && job_empty, "job taken from empty queue")
	`LGCD_ASSERT_IMPLY(a_commit_closes_run, out_valid_q && (out_q.command_kind == CMD_COMMIT), out_q.last_of_run && (out_q.cell_address == 8'd0), "commit not last of run")

endmodule

>>> design/led_grid_command_decoder.sv
// Top level of the LED grid command decoder: parser, job queue, expander.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------
//   request   | push / full          | item   (data_byte, first, bytes_left)
//   result    | empty / pop          | result (kind, address, levels, last)
//
// Parser takes one byte per cycle while the job queue has room. Expander emits one
// result per cycle while its output is empty or popped: fill or set 1 (2 with the
// commit), row or column 8 (9 with the commit), lone commit 1; it sets the rate.
// First result of a byte passes the queue entry, expander job and output registers.
// Reset (arst_n low, async) parks the parser at the red byte, empties queue and output.
// A stalled consumer backs up the four-entry job queue; full then stalls the input.
`timescale 1ns / 1ps
module led_grid_command_decoder import lgcd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lgcd_item_t   item,
	input  logic         push,
	output logic         full,
	output lgcd_result_t result,
	output logic         empty,
	input  logic         pop
);

	logic      accept;
	lgcd_job_t front_job;
	logic      front_job_valid;
	lgcd_job_t queue_job;
	logic      queue_empty;
	logic      queue_pop;

	// a request is taken whenever the job queue has a free entry
	assign accept = push && !full;

	lgcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.accept    (accept),
		.job       (front_job),
		.job_valid (front_job_valid)
	);

	// only bytes that cause results enter the queue
	lgcd_job_fifo u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_job_valid),
		.wr_data (front_job),
		.full    (full),
		.rd_en   (queue_pop),
		.rd_data (queue_job),
		.empty   (queue_empty)
	);

	// expands rows and columns to eight sets and appends the commit at a message's end
	lgcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_empty (queue_empty),
		.job_pop   (queue_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
